// ===== rtl/mcd_pkg.sv =====
// shared types and constants for the multi-click detector
`default_nettype none
package mcd_pkg;

    localparam int unsigned LenW   = 16;
    localparam int unsigned TallyW = 8;
    localparam int unsigned CfgAddrW = 2;

    localparam logic [LenW-1:0]   LenMax   = {LenW{1'b1}};
    localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

    // register indexes of the configuration port
    localparam logic [CfgAddrW-1:0] RegPressMin   = 2'd0;
    localparam logic [CfgAddrW-1:0] RegPressMax   = 2'd1;
    localparam logic [CfgAddrW-1:0] RegReleaseMin = 2'd2;
    localparam logic [CfgAddrW-1:0] RegReleaseMax = 2'd3;

    localparam logic [LenW-1:0] PressMinRst   = 16'd5;
    localparam logic [LenW-1:0] PressMaxRst   = 16'd50;
    localparam logic [LenW-1:0] ReleaseMinRst = 16'd4;
    localparam logic [LenW-1:0] ReleaseMaxRst = 16'd18;

    // beat kinds on the input tuser
    localparam logic ReqFrame = 1'b0;
    localparam logic ReqRead  = 1'b1;

    typedef struct packed {
        logic [LenW-1:0] press_min;
        logic [LenW-1:0] press_max;
        logic [LenW-1:0] release_min;
        logic [LenW-1:0] release_max;
    } cfg_t;

    typedef struct packed {
        logic [LenW-1:0]   press_len;
        logic [LenW-1:0]   release_len;
        logic [LenW-1:0]   last_press_len;
        logic [TallyW-1:0] click_tally;
        logic              click_marked;
        logic              pending_valid;
        logic [TallyW-1:0] pending_count;
    } det_state_t;

    typedef struct packed {
        logic              report_valid;
        logic [TallyW-1:0] click_count;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/mcd_update.sv =====
// next-state and result logic for one input beat
`default_nettype none
module mcd_update (
    input  wire logic               req_type,
    input  wire logic               pressed,
    input  wire mcd_pkg::cfg_t      cfg,
    input  wire mcd_pkg::det_state_t st,
    output mcd_pkg::det_state_t     st_next,
    output mcd_pkg::result_t        res
);

    mcd_pkg::det_state_t fr;
    logic                hit;

    always_comb begin
        fr = st;
        if (pressed) begin
            fr.press_len    = (st.press_len != mcd_pkg::LenMax) ?
                              st.press_len + 1'b1 : st.press_len;
            fr.release_len  = '0;
            fr.click_marked = 1'b0;
        end else begin
            if (st.press_len != '0) begin
                fr.last_press_len = st.press_len;
                fr.press_len      = '0;
            end
            fr.release_len = (st.release_len != mcd_pkg::LenMax) ?
                             st.release_len + 1'b1 : st.release_len;
        end

        hit = (fr.last_press_len >= cfg.press_min) &&
              (fr.last_press_len <= cfg.press_max) &&
              (fr.release_len >= cfg.release_min) &&
              (fr.release_len <= cfg.release_max) && !fr.click_marked;
        if (hit) begin
            if (fr.click_tally != mcd_pkg::TallyMax) begin
                fr.click_tally = fr.click_tally + 1'b1;
            end
            fr.click_marked = 1'b1;
        end

        // sequence finished: move the tally to the report
        if ((fr.release_len > cfg.release_max) && (fr.click_tally != '0)) begin
            fr.pending_valid = 1'b1;
            fr.pending_count = fr.click_tally;
            fr.click_tally   = '0;
        end

        if (req_type == mcd_pkg::ReqRead) begin
            res.report_valid      = st.pending_valid;
            res.click_count       = st.pending_valid ? st.pending_count : '0;
            st_next               = st;
            st_next.pending_valid = 1'b0;
            st_next.pending_count = '0;
        end else begin
            res.report_valid = fr.pending_valid;
            res.click_count  = fr.pending_valid ? fr.pending_count : '0;
            st_next          = fr;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/multi_click_detector_unit.sv =====
// multi-click detector top level: stream channels, config registers, state
//
// usage:
//   input beats: s_tuser[0] is the kind (0 = frame sample, 1 = read and clear),
//   s_tdata[0] is the button level for frame samples.
//   every input beat gives exactly one result beat: m_tuser[0] flags a
//   pending click report, m_tdata[7:0] holds its click count (0 without one).
//   the detector state is updated in the cycle the beat is taken and the
//   result sits in the output register from the next cycle on.
//   throughput is one beat per cycle while m_tready holds; the output register
//   is the only stage, so s_tready stays high while it is empty or being taken.
//   when the receiver stalls, the result is held and s_tready drops until
//   it is taken; no beat is lost.
//   the cfg port writes a window register (0 press_min, 1 press_max,
//   2 release_min, 3 release_max) on any cycle cfg_we is high; write only
//   while the block is idle.
//   reset (aresetn low, synchronous) clears all counters and the pending
//   report, empties the output register and reloads the register defaults
//   5, 50, 4 and 18.
`default_nettype none
module multi_click_detector_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] pressed, [7:1] zero
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] click_count
    output logic             m_tuser,   // [0] report_valid
    input  wire logic        cfg_we,
    input  wire logic [mcd_pkg::CfgAddrW-1:0] cfg_addr,
    input  wire logic [mcd_pkg::LenW-1:0]     cfg_wdata
);

    mcd_pkg::cfg_t       cfg_reg;
    mcd_pkg::det_state_t st_reg;
    mcd_pkg::det_state_t st_next;
    mcd_pkg::result_t    res_next;
    mcd_pkg::result_t    res_reg;
    logic                out_valid_reg;
    logic                in_fire;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    mcd_update u_update (
        .req_type (s_tuser),
        .pressed  (s_tdata[0]),
        .cfg      (cfg_reg),
        .st       (st_reg),
        .st_next  (st_next),
        .res      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_min   <= mcd_pkg::PressMinRst;
            cfg_reg.press_max   <= mcd_pkg::PressMaxRst;
            cfg_reg.release_min <= mcd_pkg::ReleaseMinRst;
            cfg_reg.release_max <= mcd_pkg::ReleaseMaxRst;
        end else if (cfg_we) begin
            case (cfg_addr)
                mcd_pkg::RegPressMin:   cfg_reg.press_min   <= cfg_wdata;
                mcd_pkg::RegPressMax:   cfg_reg.press_max   <= cfg_wdata;
                mcd_pkg::RegReleaseMin: cfg_reg.release_min <= cfg_wdata;
                mcd_pkg::RegReleaseMax: cfg_reg.release_max <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                st_reg <= st_next;
            end
            if (in_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg.click_count;
    assign m_tuser  = res_reg.report_valid;

endmodule
`default_nettype wire
